// ----- src/assert_macros.svh -----
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- src/utf8sd_pkg.sv -----
// Types, constants and helpers shared by the UTF-8 stream decoder.
package utf8sd_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam logic [31:0] BAD_MARKER_RESET = 32'hFFFF_FFFE;

	// One classified item handed from the front to the back.
	typedef struct packed {
		logic [30:0] code;       // payload of the first result
		logic        bad;        // first result is the bad marker
		logic        has_second; // an ASCII result follows
		logic [6:0]  second_ch;  // the ASCII character of that result
	} utf8sd_entry_t;

	// Least code value allowed for a sequence of the given length.
	function automatic logic [30:0] least_value(input logic [2:0] len);
		logic [30:0] v;
		case (len)
			3'd2: v = 31'h0000_0080;
			3'd3: v = 31'h0000_0800;
			3'd4: v = 31'h0001_0000;
			3'd5: v = 31'h0020_0000;
			3'd6: v = 31'h0400_0000;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- src/utf8_stream_decoder.sv -----
// Top level of the byte-serial UTF-8 decoder (one- to six-byte forms).
//
//   channel   ports                                  handshake
//   bytes in  in_byte                                push / full
//   results   code_point, is_bad, last_of_run        empty / pop
//   config    bad_marker                             bad_marker_we
//
// One byte is taken per cycle while the item queue between front and back
// has room; the front updates its sequence state with each accepted byte.
// A result shows on the ports once its entry reaches the head of the item queue.
// A byte that breaks a sequence and is ASCII gives two results, which leave
// over two pops; an entry is freed with the last result of its byte, so up to
// QueueDepth bytes that give results can wait; bytes that give none take no entry.
// Reset clears the sequence state and the queue and sets bad_marker to 0xFFFFFFFE.
module utf8_stream_decoder #(
	parameter int unsigned QueueDepth = utf8sd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] code_point,
	output logic        is_bad,
	output logic        last_of_run,
	input  logic        bad_marker_we,
	input  logic [31:0] bad_marker
);
	import utf8sd_pkg::*;

	utf8sd_entry_t q_wdata;
	utf8sd_entry_t q_head;
	logic          q_wr;
	logic          q_rd;
	logic          q_full;
	logic          q_empty;

	utf8sd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_byte (in_byte),
		.full    (full),
		.q_full  (q_full),
		.q_wr    (q_wr),
		.q_wdata (q_wdata)
	);

	utf8sd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.rd_en   (q_rd),
		.rd_data (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	utf8sd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.bad_marker_we (bad_marker_we),
		.bad_marker    (bad_marker),
		.head          (q_head),
		.q_empty       (q_empty),
		.q_rd          (q_rd),
		.pop           (pop),
		.empty         (empty),
		.code_point    (code_point),
		.is_bad        (is_bad),
		.last_of_run   (last_of_run)
	);

endmodule

// ----- src/utf8sd_front.sv -----
// Front end: accepts bytes, tracks the open sequence and classifies results.
module utf8sd_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [7:0]               in_byte,
	output logic                     full,
	input  logic                     q_full,
	output logic                     q_wr,
	output utf8sd_pkg::utf8sd_entry_t q_wdata
);
	import utf8sd_pkg::*;

	logic [30:0] partial_q, partial_d;
	logic [2:0]  expected_q, expected_d;
	logic [2:0]  seen_q, seen_d;
	logic        lead_inv_q, lead_inv_d;

	logic        accept;
	logic        is_ascii;
	logic        is_cont;
	logic [2:0]  lead_len;
	logic [30:0] lead_bits;
	logic        lead_inv;
	logic [30:0] cont_code;
	logic [2:0]  seen_inc;

	assign full     = q_full;
	assign accept   = push && !q_full;
	assign is_ascii = !in_byte[7];
	assign is_cont  = (in_byte[7:6] == 2'b10);
	assign cont_code = {partial_q[24:0], in_byte[5:0]};
	assign seen_inc  = seen_q + 3'd1;

	// Length and payload bits of a lead byte.
	always_comb begin
		lead_len  = 3'd0;
		lead_bits = '0;
		lead_inv  = 1'b0;
		case (in_byte) inside
			[8'hC0:8'hDF]: begin
				lead_len  = 3'd2;
				lead_bits = {26'd0, in_byte[4:0]};
			end
			[8'hE0:8'hEF]: begin
				lead_len  = 3'd3;
				lead_bits = {27'd0, in_byte[3:0]};
			end
			[8'hF0:8'hF7]: begin
				lead_len  = 3'd4;
				lead_bits = {28'd0, in_byte[2:0]};
			end
			[8'hF8:8'hFB]: begin
				lead_len  = 3'd5;
				lead_bits = {29'd0, in_byte[1:0]};
			end
			[8'hFC:8'hFD]: begin
				lead_len  = 3'd6;
				lead_bits = {30'd0, in_byte[0]};
			end
			[8'hFE:8'hFF]: begin
				lead_len  = 3'd5;
				lead_inv  = 1'b1;
			end
			default: begin
				lead_len  = 3'd0;
			end
		endcase
	end

	always_comb begin
		partial_d  = partial_q;
		expected_d = expected_q;
		seen_d     = seen_q;
		lead_inv_d = lead_inv_q;
		q_wr       = 1'b0;
		q_wdata    = '0;
		if (accept) begin
			if (expected_q == 3'd0) begin
				if (is_ascii) begin
					q_wr         = 1'b1;
					q_wdata.code = {24'd0, in_byte[6:0]};
				end else if (is_cont) begin
					q_wr        = 1'b1;
					q_wdata.bad = 1'b1;
				end else begin
					partial_d  = lead_bits;
					expected_d = lead_len;
					seen_d     = 3'd1;
					lead_inv_d = lead_inv;
				end
			end else if (is_cont) begin
				partial_d = cont_code;
				seen_d    = seen_inc;
				if (seen_inc >= expected_q) begin
					q_wr         = 1'b1;
					q_wdata.code = cont_code;
					q_wdata.bad  = lead_inv_q || (cont_code < least_value(expected_q));
					partial_d    = '0;
					expected_d   = 3'd0;
					seen_d       = 3'd0;
					lead_inv_d   = 1'b0;
				end
			end else begin
				// Break the open sequence, then decode this byte afresh.
				q_wr               = 1'b1;
				q_wdata.bad        = 1'b1;
				q_wdata.has_second = is_ascii;
				q_wdata.second_ch  = in_byte[6:0];
				if (is_ascii) begin
					partial_d  = '0;
					expected_d = 3'd0;
					seen_d     = 3'd0;
					lead_inv_d = 1'b0;
				end else begin
					partial_d  = lead_bits;
					expected_d = lead_len;
					seen_d     = 3'd1;
					lead_inv_d = lead_inv;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q  <= '0;
			expected_q <= 3'd0;
			seen_q     <= 3'd0;
			lead_inv_q <= 1'b0;
		end else begin
			partial_q  <= partial_d;
			expected_q <= expected_d;
			seen_q     <= seen_d;
			lead_inv_q <= lead_inv_d;
		end
	end

	`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_seq_count, expected_q != 3'd0, (seen_q != 3'd0) && (seen_q < expected_q), "open sequence has bad byte count")

endmodule

// ----- src/utf8sd_queue.sv -----
// Short flop queue of classified items between front and back.
module utf8sd_queue #(
	parameter int unsigned Depth = utf8sd_pkg::QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  utf8sd_pkg::utf8sd_entry_t wr_data,
	input  logic                      rd_en,
	output utf8sd_pkg::utf8sd_entry_t rd_data,
	output logic                      full,
	output logic                      empty
);
	import utf8sd_pkg::*;

	localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	utf8sd_entry_t   mem_q [Depth];
	logic [IdxW-1:0] wr_ptr_q;
	logic [IdxW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_no_overflow, wr_en, !full, "write into a full queue")
	`ASSERT_ALWAYS(a_count_range, count_q <= CntW'(Depth), "queue count out of range")

endmodule

// ----- src/utf8sd_back.sv -----
// Back end: expands each queued item into one or two results.
module utf8sd_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      bad_marker_we,
	input  logic [31:0]               bad_marker,
	input  utf8sd_pkg::utf8sd_entry_t head,
	input  logic                      q_empty,
	output logic                      q_rd,
	input  logic                      pop,
	output logic                      empty,
	output logic [31:0]               code_point,
	output logic                      is_bad,
	output logic                      last_of_run
);
	import utf8sd_pkg::*;

	logic [31:0] marker_q;
	logic        second_q;
	logic        fire;

	assign empty       = q_empty;
	assign fire        = pop && !q_empty;
	assign last_of_run = second_q || !head.has_second;
	assign is_bad      = !second_q && head.bad;
	assign code_point  = second_q ? {25'd0, head.second_ch}
	                   : (head.bad ? marker_q : {1'b0, head.code});
	// Release the queue entry with its last result.
	assign q_rd        = fire && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= BAD_MARKER_RESET;
			second_q <= 1'b0;
		end else begin
			if (bad_marker_we) begin
				marker_q <= bad_marker;
			end
			if (fire) begin
				second_q <= !last_of_run;
			end
		end
	end

	`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_second_valid, second_q, !q_empty && head.has_second, "second result without its item")

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the byte-serial UTF-8 stream decoder.
module tb;
	import utf8sd_pkg::*;

	localparam int unsigned LATENCY    = 4;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned PHASE_BYTES = 220;

	typedef struct packed {
		logic [31:0] code;
		logic        bad;
		logic        last;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  in_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] code_point;
	logic        is_bad;
	logic        last_of_run;
	logic        bad_marker_we = 1'b0;
	logic [31:0] bad_marker = 32'h0;

	// decoder image
	logic [30:0] seq_code = '0;
	logic [2:0]  seq_len = '0;
	logic [2:0]  seq_seen = '0;
	logic        seq_bad_lead = 1'b0;
	logic [31:0] marker = BAD_MARKER_RESET;

	logic [7:0]  tx_bytes[$];
	result_t     pending_results[$];
	int unsigned queued_bytes = 0;
	int unsigned mismatches = 0;
	int unsigned tx_idle = 24;
	int unsigned rx_idle = 24;
	int unsigned stall_cycles = 0;
	logic        drain_hold = 1'b0;
	logic        drained = 1'b1;
	result_t     want;

	utf8_stream_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_byte      (in_byte),
		.empty        (empty),
		.pop          (pop),
		.code_point   (code_point),
		.is_bad       (is_bad),
		.last_of_run  (last_of_run),
		.bad_marker_we(bad_marker_we),
		.bad_marker   (bad_marker)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [30:0] floor_of(input int len);
		case (len)
			2: return 31'h0000_0080;
			3: return 31'h0000_0800;
			4: return 31'h0001_0000;
			5: return 31'h0020_0000;
			6: return 31'h0400_0000;
			default: return '0;
		endcase
	endfunction

	task automatic note_result(input logic [31:0] code, input logic bad);
		result_t r;
		r.code = code;
		r.bad  = bad;
		r.last = 1'b0;
		pending_results.push_back(r);
	endtask

	task automatic close_seq();
		seq_code = '0;
		seq_len = '0;
		seq_seen = '0;
		seq_bad_lead = 1'b0;
	endtask

	task automatic open_fresh(input logic [7:0] b);
		if (b < 8'h80) begin
			note_result({24'd0, b}, 1'b0);
		end else if (b < 8'hC0) begin
			note_result(marker, 1'b1);
		end else begin
			seq_seen = 3'd1;
			seq_bad_lead = 1'b0;
			if (b < 8'hE0) begin
				seq_len = 3'd2;
				seq_code = {26'd0, b[4:0]};
			end else if (b < 8'hF0) begin
				seq_len = 3'd3;
				seq_code = {27'd0, b[3:0]};
			end else if (b < 8'hF8) begin
				seq_len = 3'd4;
				seq_code = {28'd0, b[2:0]};
			end else if (b < 8'hFC) begin
				seq_len = 3'd5;
				seq_code = {29'd0, b[1:0]};
			end else if (b < 8'hFE) begin
				seq_len = 3'd6;
				seq_code = {30'd0, b[0]};
			end else begin
				// 0xFE and 0xFF swallow four more bytes, then report bad
				seq_len = 3'd5;
				seq_code = '0;
				seq_bad_lead = 1'b1;
			end
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		int n0;
		result_t r;
		n0 = pending_results.size();
		if (seq_len == 3'd0) begin
			open_fresh(b);
		end else if (b[7:6] == 2'b10) begin
			seq_code = {seq_code[24:0], b[5:0]};
			seq_seen = seq_seen + 3'd1;
			if (seq_seen >= seq_len) begin
				if (seq_bad_lead || seq_code < floor_of(seq_len))
					note_result(marker, 1'b1);
				else
					note_result({1'b0, seq_code}, 1'b0);
				close_seq();
			end
		end else begin
			// break the open sequence, then decode this byte afresh
			note_result(marker, 1'b1);
			close_seq();
			open_fresh(b);
		end
		if (pending_results.size() > n0) begin
			r = pending_results.pop_back();
			r.last = 1'b1;
			pending_results.push_back(r);
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				decode_byte(in_byte);
			if (!(push && full)) begin
				if (!drain_hold && tx_bytes.size() > 0 && $urandom_range(299) == 0)
					drain_hold = 1'b1;
				else if (drain_hold && drained && !push)
					drain_hold = 1'b0;
				if (tx_bytes.size() > 0 && !drain_hold && $urandom_range(99) >= tx_idle) begin
					push <= 1'b1;
					in_byte <= tx_bytes.pop_front();
				end else begin
					push <= 1'b0;
					in_byte <= 8'($urandom);
				end
			end
		end
	end

	always @(negedge clk) begin
		drained = (pending_results.size() == 0);
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: code=%h bad=%0d last=%0d",
							code_point, is_bad, last_of_run);
				end else begin
					want = pending_results.pop_front();
					if (code_point !== want.code || is_bad !== want.bad
							|| last_of_run !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: want code=%h bad=%0d last=%0d, got code=%h bad=%0d last=%0d",
								want.code, want.bad, want.last,
								code_point, is_bad, last_of_run);
					end
				end
			end
			pop <= ($urandom_range(99) >= rx_idle);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || bad_marker_we)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic add_byte(input logic [7:0] b);
		tx_bytes.push_back(b);
		queued_bytes++;
	endtask

	task automatic add_char(input int len, input logic [30:0] value);
		logic [7:0] prefix;
		case (len)
			2: prefix = 8'hC0;
			3: prefix = 8'hE0;
			4: prefix = 8'hF0;
			5: prefix = 8'hF8;
			6: prefix = 8'hFC;
			default: prefix = 8'h00;
		endcase
		add_byte(prefix | 8'(value >> (6 * (len - 1))));
		for (int k = len - 2; k >= 0; k--)
			add_byte(8'h80 | 8'((value >> (6 * k)) & 31'd63));
	endtask

	task automatic add_random_item();
		int kind;
		int len;
		int pick;
		logic [7:0] b;
		logic [30:0] top;
		kind = $urandom_range(99);
		pick = $urandom_range(99);
		if (pick < 30) len = 1;
		else if (pick < 50) len = 2;
		else if (pick < 65) len = 3;
		else if (pick < 78) len = 4;
		else if (pick < 89) len = 5;
		else len = 6;
		if (kind < 62) begin
			if (len == 1) begin
				add_byte(8'($urandom_range(127)));
			end else begin
				top = (31'd1 << (5 * 1 + 6 * (len - 1) - (len - 2))) - 31'd1;
				// payload bits: 11, 16, 21, 26, 31 for two to six bytes
				case (len)
					2: top = 31'h0000_07FF;
					3: top = 31'h0000_FFFF;
					4: top = 31'h001F_FFFF;
					5: top = 31'h03FF_FFFF;
					default: top = 31'h7FFF_FFFF;
				endcase
				add_char(len, 31'($urandom_range(top, floor_of(len))));
			end
		end else if (kind < 70) begin
			if (len == 1) len = 2;
			add_char(len, 31'($urandom_range(floor_of(len) - 31'd1, 0)));
		end else if (kind < 78) begin
			add_byte($urandom_range(1) ? 8'hFF : 8'hFE);
			for (int k = 0; k < 4; k++)
				add_byte(8'h80 | 8'($urandom_range(63)));
		end else if (kind < 88) begin
			if (len == 1) len = 2;
			case (len)
				2: add_byte(8'($urandom_range(8'hDF, 8'hC0)));
				3: add_byte(8'($urandom_range(8'hEF, 8'hE0)));
				4: add_byte(8'($urandom_range(8'hF7, 8'hF0)));
				5: add_byte(8'($urandom_range(8'hFB, 8'hF8)));
				default: add_byte(8'($urandom_range(8'hFD, 8'hFC)));
			endcase
			for (int k = $urandom_range(len - 2); k > 0; k--)
				add_byte(8'h80 | 8'($urandom_range(63)));
			b = 8'($urandom_range(255));
			if (b[7:6] == 2'b10)
				b[6] = 1'b1;
			add_byte(b);
		end else begin
			add_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (tx_bytes.size() != 0 || push || pending_results.size() != 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_marker(input logic [31:0] value);
		@(posedge clk);
		bad_marker_we <= 1'b1;
		bad_marker <= value;
		marker = value;
		@(posedge clk);
		bad_marker_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [31:0] value, input int unsigned idle_pct);
		wait_idle();
		write_marker(value);
		tx_idle = idle_pct;
		rx_idle = idle_pct;
		queued_bytes = 0;
		while (queued_bytes < PHASE_BYTES)
			add_random_item();
		// leave no sequence open across a register write
		add_byte(8'h41);
	endtask

	initial begin
		// ASCII extremes and stray continuations
		add_byte(8'h00);
		add_byte(8'h7F);
		add_byte(8'h80);
		add_byte(8'hBF);
		// least two-byte form, overlong two-byte, largest three-byte
		add_char(2, 31'h80);
		add_byte(8'hC0);
		add_byte(8'h80);
		add_char(3, 31'hFFFF);
		// largest six-byte value
		add_char(6, 31'h7FFF_FFFF);
		// invalid lead swallows four continuations
		add_byte(8'hFE);
		repeat (4) add_byte(8'hBF);
		// invalid lead broken by a lead, broken again by ASCII
		add_byte(8'hFF);
		add_byte(8'hC3);
		add_byte(8'h41);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_phase(32'h0000_0000, 24);
		run_phase(32'hFFFF_FFFF, 0);
		// marker equal to an ASCII character; only is_bad tells them apart
		run_phase(32'h0000_0041, 24);
		run_phase($urandom, 24);

		wait_idle();
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
